// ----- sv/prg_pkg.sv -----
package prg_pkg;

   localparam int unsigned COORD_W      = 16;
   localparam int unsigned BOUNDS_W     = 64;
   localparam int unsigned STRIDE_W     = 8;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned R2_W         = 32;

   // default depth of the queue between front and back
   localparam int unsigned PRG_QUEUE_DEPTH = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_OBS_LOWER   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OBS_UPPER   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CLR_LOWER   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CLR_UPPER   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CLR_STRIDE  = 3'd4;

   // reset values of the registers
   localparam logic [BOUNDS_W-1:0] OBS_LOWER_RESET  = 64'd84443996251750700;
   localparam logic [BOUNDS_W-1:0] OBS_UPPER_RESET  = 64'd562954248421378000;
   localparam logic [BOUNDS_W-1:0] CLR_LOWER_RESET  = 64'd84721820506259756;
   localparam logic [BOUNDS_W-1:0] CLR_UPPER_RESET  = 64'd1125906349457412000;
   localparam logic [STRIDE_W-1:0] CLR_STRIDE_RESET = 8'd2;

   // classified point travelling from front to back
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      cloud_start;
      logic                      clear_hit;
      logic                      obstacle_hit;
   } prg_item_type;

   // handshake of one queue side
   typedef struct packed {
      logic valid;
      logic ready;
   } prg_hs_type;

endpackage

// ----- sv/prg_if.sv -----
interface prg_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;
   logic signed [15:0] point_z;
   logic               is_finite;
   logic               cloud_start;

   modport source(output valid, point_x, point_y, point_z, is_finite, cloud_start,
                  input ready);
   modport sink(input valid, point_x, point_y, point_z, is_finite, cloud_start,
                output ready);
endinterface

interface prg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_x;
   logic signed [15:0] out_y;
   logic signed [15:0] out_z;
   logic               mark_obstacle;
   logic               emit_clearing;

   modport source(output valid, out_x, out_y, out_z, mark_obstacle, emit_clearing,
                  input ready);
   modport sink(input valid, out_x, out_y, out_z, mark_obstacle, emit_clearing,
                output ready);
endinterface

interface prg_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] wdata;

   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface

// ----- sv/point_cloud_roi_gate_core.sv -----
// path: a request passes through the stage a register, the queue and the result register
// throughput: one request per cycle while results are taken; the front register, queue
//    and output register each move one request a cycle, and the stride phase updates on each load
// reset: synchronous, clears the valid flags, queue pointers and stride phase and
//    loads the default gate bounds and stride
module point_cloud_roi_gate_core
   import prg_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = PRG_QUEUE_DEPTH
)
(
   input  logic      clock,
   input  logic      reset,
   prg_req_if.sink   req_bus,
   prg_rsp_if.source rsp_bus,
   prg_csr_if.sink   csr_bus
);

   // gate bounds and stride registers
   logic [BOUNDS_W-1:0] obs_lower_ff, obs_upper_ff;
   logic [BOUNDS_W-1:0] clr_lower_ff, clr_upper_ff;
   logic [STRIDE_W-1:0] clr_stride_ff;

   // front to queue
   prg_hs_type   push_hs;
   logic         push_ready;
   prg_item_type push_item;

   // queue to back
   prg_hs_type   pop_hs;
   logic         pop_ready;
   prg_item_type pop_item;

   // writes land directly in the registers, so the port never stalls
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         obs_lower_ff  <= OBS_LOWER_RESET;
         obs_upper_ff  <= OBS_UPPER_RESET;
         clr_lower_ff  <= CLR_LOWER_RESET;
         clr_upper_ff  <= CLR_UPPER_RESET;
         clr_stride_ff <= CLR_STRIDE_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_OBS_LOWER:  obs_lower_ff  <= csr_bus.wdata;
            REG_OBS_UPPER:  obs_upper_ff  <= csr_bus.wdata;
            REG_CLR_LOWER:  clr_lower_ff  <= csr_bus.wdata;
            REG_CLR_UPPER:  clr_upper_ff  <= csr_bus.wdata;
            REG_CLR_STRIDE: clr_stride_ff <= csr_bus.wdata[STRIDE_W-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // front: abs y and squared range, then both gate tests
   prg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .obs_lower   (obs_lower_ff),
      .obs_upper   (obs_upper_ff),
      .clr_lower   (clr_lower_ff),
      .clr_upper   (clr_upper_ff),
      .push_hs_out (push_hs),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   // short queue so front and back stall independently
   prg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_hs.valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_hs     (pop_hs),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // back: stride thinning of clearing points and the result register
   prg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_hs     (pop_hs),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .clr_stride (clr_stride_ff),
      .rsp        (rsp_bus)
   );

endmodule

// ----- sv/prg_front.sv -----
module prg_front
   import prg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   prg_req_if.sink             req,
   input  logic [BOUNDS_W-1:0] obs_lower,
   input  logic [BOUNDS_W-1:0] obs_upper,
   input  logic [BOUNDS_W-1:0] clr_lower,
   input  logic [BOUNDS_W-1:0] clr_upper,
   output prg_hs_type          push_hs_out,
   input  logic                push_ready,
   output prg_item_type        push_item
);

   function automatic logic [R2_W-1:0] range_square(input logic signed [COORD_W-1:0] r);
      logic signed [R2_W-1:0] rs;
      logic signed [R2_W-1:0] p;
      rs = R2_W'(r);
      p  = rs * rs;
      return unsigned'(p);
   endfunction

   function automatic logic gate_hit(
      input logic [BOUNDS_W-1:0]       lo_w,
      input logic [BOUNDS_W-1:0]       hi_w,
      input logic [R2_W-1:0]           lo_sq,
      input logic [R2_W-1:0]           hi_sq,
      input logic signed [COORD_W-1:0] x,
      input logic signed [COORD_W-1:0] ay,
      input logic signed [COORD_W-1:0] z,
      input logic [R2_W-1:0]           r2
   );
      logic signed [COORD_W-1:0] lo_x, lo_ay, lo_z, lo_r;
      logic signed [COORD_W-1:0] hi_x, hi_ay, hi_z, hi_r;
      logic                      hit;
      lo_x  = signed'(lo_w[15:0]);
      lo_ay = signed'(lo_w[31:16]);
      lo_z  = signed'(lo_w[47:32]);
      lo_r  = signed'(lo_w[63:48]);
      hi_x  = signed'(hi_w[15:0]);
      hi_ay = signed'(hi_w[31:16]);
      hi_z  = signed'(hi_w[47:32]);
      hi_r  = signed'(hi_w[63:48]);
      hit = 1'b1;
      if (x < lo_x || x > hi_x) hit = 1'b0;
      if (ay < lo_ay || ay > hi_ay) hit = 1'b0;
      if (z < lo_z || z > hi_z) hit = 1'b0;
      // negative minimum never rejects, negative maximum always rejects
      if (lo_r > 16'sd0 && r2 < lo_sq) hit = 1'b0;
      if (hi_r < 16'sd0 || r2 > hi_sq) hit = 1'b0;
      return hit;
   endfunction

   // squared range bounds, refreshed every cycle from the registers
   logic [R2_W-1:0] obs_lo_sq_ff, obs_hi_sq_ff, clr_lo_sq_ff, clr_hi_sq_ff;

   // stage a: point with abs y and squared planar range
   logic                      a_valid_ff, a_valid_in;
   logic signed [COORD_W-1:0] a_x_ff, a_y_ff, a_z_ff, a_ay_ff;
   logic signed [COORD_W-1:0] ay_in;
   logic [R2_W-1:0]           a_r2_ff, r2_in;
   logic                      a_finite_ff, a_start_ff;
   logic                      a_advance;
   logic signed [R2_W-1:0]    x_sq, y_sq;

   always_ff @(posedge clock) begin
      obs_lo_sq_ff <= range_square(signed'(obs_lower[63:48]));
      obs_hi_sq_ff <= range_square(signed'(obs_upper[63:48]));
      clr_lo_sq_ff <= range_square(signed'(clr_lower[63:48]));
      clr_hi_sq_ff <= range_square(signed'(clr_upper[63:48]));
   end

   assign a_advance = !a_valid_ff || push_ready;
   assign req.ready = a_advance;

   always_comb begin
      if (req.point_y == 16'sh8000) begin
         ay_in = 16'sh7fff;
      end else if (req.point_y < 16'sd0) begin
         ay_in = -req.point_y;
      end else begin
         ay_in = req.point_y;
      end
      x_sq  = R2_W'(req.point_x) * R2_W'(req.point_x);
      y_sq  = R2_W'(req.point_y) * R2_W'(req.point_y);
      r2_in = unsigned'(x_sq) + unsigned'(y_sq);
      a_valid_in = a_advance ? req.valid : a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && a_advance) begin
         a_x_ff      <= req.point_x;
         a_y_ff      <= req.point_y;
         a_z_ff      <= req.point_z;
         a_ay_ff     <= ay_in;
         a_r2_ff     <= r2_in;
         a_finite_ff <= req.is_finite;
         a_start_ff  <= req.cloud_start;
      end
   end

   // classification feeds the queue straight from stage a
   always_comb begin
      push_hs_out.valid      = a_valid_ff;
      push_hs_out.ready      = push_ready;
      push_item.x            = a_x_ff;
      push_item.y            = a_y_ff;
      push_item.z            = a_z_ff;
      push_item.cloud_start  = a_start_ff;
      push_item.clear_hit    = a_finite_ff &&
         gate_hit(clr_lower, clr_upper, clr_lo_sq_ff, clr_hi_sq_ff,
                  a_x_ff, a_ay_ff, a_z_ff, a_r2_ff);
      push_item.obstacle_hit = a_finite_ff &&
         gate_hit(obs_lower, obs_upper, obs_lo_sq_ff, obs_hi_sq_ff,
                  a_x_ff, a_ay_ff, a_z_ff, a_r2_ff);
   end

endmodule

// ----- sv/prg_queue.sv -----
module prg_queue
   import prg_pkg::*;
#(
   parameter int unsigned DEPTH = PRG_QUEUE_DEPTH
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  prg_item_type push_item,
   output prg_hs_type   pop_hs,
   input  logic         pop_ready,
   output prg_item_type pop_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   prg_item_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready   = count_ff != CNT_W'(DEPTH);
   assign pop_hs.valid = count_ff != '0;
   assign pop_hs.ready = pop_ready;
   assign pop_item     = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_hs.valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- sv/prg_back.sv -----
module prg_back
   import prg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  prg_hs_type          pop_hs,
   output logic                pop_ready,
   input  prg_item_type        pop_item,
   input  logic [STRIDE_W-1:0] clr_stride,
   prg_rsp_if.source           rsp
);

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic                      mark_ff, emit_ff, emit_in;
   logic [STRIDE_W-1:0]       phase_ff, phase_in, phase_cur;
   logic [STRIDE_W-1:0]       stride_eff;
   logic [STRIDE_W:0]         phase_inc;
   logic                      load;

   assign pop_ready = !rsp_valid_ff || rsp.ready;
   assign load      = pop_hs.valid && pop_ready;

   always_comb begin
      stride_eff = (clr_stride == '0) ? STRIDE_W'(1) : clr_stride;
      phase_cur  = pop_item.cloud_start ? '0 : phase_ff;
      phase_inc  = {1'b0, phase_cur} + 1'b1;
      emit_in    = 1'b0;
      phase_in   = phase_ff;
      if (load) begin
         phase_in = phase_cur;
         if (pop_item.clear_hit) begin
            emit_in  = phase_cur == '0;
            phase_in = (phase_inc >= {1'b0, stride_eff}) ? '0 : phase_inc[STRIDE_W-1:0];
         end
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_x_ff <= pop_item.x;
         out_y_ff <= pop_item.y;
         out_z_ff <= pop_item.z;
         mark_ff  <= pop_item.obstacle_hit;
         emit_ff  <= emit_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_x         = out_x_ff;
   assign rsp.out_y         = out_y_ff;
   assign rsp.out_z         = out_z_ff;
   assign rsp.mark_obstacle = mark_ff;
   assign rsp.emit_clearing = emit_ff;

endmodule

// ----- verif/tb_top.sv -----
module tb_top
   import prg_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // run shape
   localparam int unsigned NUM_REGS       = 5;
   localparam int unsigned PHASES         = 14;
   localparam int unsigned PHASE_POINTS   = 125;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned HOLD_PHASE     = 11;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned MAX_REPORTS    = 10;

   // gate words that open every box and the range band as far as possible
   localparam logic [BOUNDS_W-1:0] WIDE_LOWER = {4{16'h8000}};
   localparam logic [BOUNDS_W-1:0] WIDE_UPPER = {4{16'h7FFF}};

   // one lidar point as offered on the request channel
   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      finite;
      logic                      start;
   } roi_point_type;

   // one gated point as seen on the result channel
   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      mark;
      logic                      emit;
   } roi_result_type;

   // mirror of the gate registers and stride phase, plus the queue of expected gated points
   class roi_scoreboard;
      logic [BOUNDS_W-1:0] obs_lo;
      logic [BOUNDS_W-1:0] obs_hi;
      logic [BOUNDS_W-1:0] clr_lo;
      logic [BOUNDS_W-1:0] clr_hi;
      logic [STRIDE_W-1:0] stride;
      int unsigned         phase;
      roi_result_type      gated_q[$];
      int unsigned         failures;

      function new();
         obs_lo   = OBS_LOWER_RESET;
         obs_hi   = OBS_UPPER_RESET;
         clr_lo   = CLR_LOWER_RESET;
         clr_hi   = CLR_UPPER_RESET;
         stride   = CLR_STRIDE_RESET;
         phase    = 0;
         failures = 0;
      endfunction

      // signed 16-bit bound k of a packed gate word: x, abs y, z, range
      static function int field(logic [BOUNDS_W-1:0] w, int k);
         logic signed [COORD_W-1:0] f;
         f = w[16*k +: 16];
         return int'(f);
      endfunction

      static function bit gate_pass(logic [BOUNDS_W-1:0] lo_w, logic [BOUNDS_W-1:0] hi_w,
                                    int x, int ay, int z, longint r2);
         longint lr;
         longint hr;
         lr = longint'(field(lo_w, 3));
         hr = longint'(field(hi_w, 3));
         if (x < field(lo_w, 0) || x > field(hi_w, 0)) return 1'b0;
         if (ay < field(lo_w, 1) || ay > field(hi_w, 1)) return 1'b0;
         if (z < field(lo_w, 2) || z > field(hi_w, 2)) return 1'b0;
         // a negative range minimum always passes, a negative maximum never does
         if (lr > 0 && r2 < lr * lr) return 1'b0;
         if (hr < 0 || r2 > hr * hr) return 1'b0;
         return 1'b1;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [BOUNDS_W-1:0] v);
         case (idx)
            REG_OBS_LOWER:  obs_lo = v;
            REG_OBS_UPPER:  obs_hi = v;
            REG_CLR_LOWER:  clr_lo = v;
            REG_CLR_UPPER:  clr_hi = v;
            REG_CLR_STRIDE: stride = v[STRIDE_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(roi_point_type p);
         int             x;
         int             y;
         int             z;
         int             ay;
         longint         r2;
         int unsigned    eff_stride;
         roi_result_type e;
         x  = int'(p.x);
         y  = int'(p.y);
         z  = int'(p.z);
         e.x = p.x;
         e.y = p.y;
         e.z = p.z;
         e.mark = 1'b0;
         e.emit = 1'b0;
         // stride zero acts as one
         eff_stride = (stride == 0) ? 1 : int'(stride);
         if (p.start) phase = 0;
         // abs(-32768) saturates
         ay = (y < 0) ? -y : y;
         if (ay > 32767) ay = 32767;
         r2 = longint'(x) * longint'(x) + longint'(y) * longint'(y);
         // non-finite points keep both flags low and leave the stride phase alone
         if (p.finite) begin
            if (gate_pass(clr_lo, clr_hi, x, ay, z, r2)) begin
               e.emit = (phase == 0);
               phase = phase + 1;
               if (phase >= eff_stride) phase = 0;
            end
            e.mark = gate_pass(obs_lo, obs_hi, x, ay, z, r2);
         end
         gated_q = {gated_q, e};
      endfunction

      function void check_result(roi_result_type got);
         roi_result_type e;
         if (gated_q.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected result x=%0d y=%0d z=%0d mark=%0b emit=%0b",
                        got.x, got.y, got.z, got.mark, got.emit);
            return;
         end
         e = gated_q.pop_front();
         if (got.x !== e.x || got.y !== e.y || got.z !== e.z ||
             got.mark !== e.mark || got.emit !== e.emit) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $write("result mismatch: expected x=%0d y=%0d z=%0d mark=%0b emit=%0b,",
                      e.x, e.y, e.z, e.mark, e.emit);
               $display(" got x=%0d y=%0d z=%0d mark=%0b emit=%0b",
                        got.x, got.y, got.z, got.mark, got.emit);
            end
         end
      endfunction

      function int pending();
         return gated_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   prg_req_if req_bus();
   prg_rsp_if rsp_bus();
   prg_csr_if csr_bus();

   point_cloud_roi_gate_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   roi_scoreboard sb = new();

   // idle percentages for sender and receiver, changed per stretch of the run
   int unsigned send_idle_pct = 17;
   int unsigned recv_idle_pct = 87;

   // long receiver hold-off so the queue fills and the request side backs up
   bit   hold_req    = 1'b0;
   logic hold_active = 1'b0;

   int unsigned idle_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver readiness: random per cycle unless a hold-off is running
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_active) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // hold-off counted here, apart from the request driver
   initial begin
      wait (hold_req);
      @(posedge clock);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   // every accepted result goes to the scoreboard
   always @(posedge clock) begin : result_monitor
      roi_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.x    = rsp_bus.out_x;
         got.y    = rsp_bus.out_y;
         got.z    = rsp_bus.out_z;
         got.mark = rsp_bus.mark_obstacle;
         got.emit = rsp_bus.emit_clearing;
         sb.check_result(got);
      end
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("point_cloud_roi_gate_core verification failed");
         $finish;
      end
   end

   function automatic roi_point_type pt(int x, int y, int z, bit finite, bit start);
      roi_point_type p;
      p.x      = 16'(x);
      p.y      = 16'(y);
      p.z      = 16'(z);
      p.finite = finite;
      p.start  = start;
      return p;
   endfunction

   function automatic logic [BOUNDS_W-1:0] pack4(int x, int ay, int z, int r);
      return {r[15:0], z[15:0], ay[15:0], x[15:0]};
   endfunction

   // plausible crop box with range band; range minimum is negative now and then
   function automatic void random_box(output logic [BOUNDS_W-1:0] lo,
                                      output logic [BOUNDS_W-1:0] hi);
      int xl;
      int al;
      int zl;
      int rl;
      xl = int'($urandom_range(6000)) - 3000;
      al = int'($urandom_range(500));
      zl = int'($urandom_range(2000)) - 1500;
      rl = int'($urandom_range(3000)) - 500;
      lo = pack4(xl, al, zl, rl);
      hi = pack4(xl + int'($urandom_range(6000)), al + int'($urandom_range(4000)),
                 zl + int'($urandom_range(3000)), rl + int'($urandom_range(6000)));
   endfunction

   // coordinate a couple of millimeters from some current bound, either sign
   function automatic logic [COORD_W-1:0] near_bound();
      logic [BOUNDS_W-1:0] w;
      int                  v;
      case ($urandom_range(3))
         0:       w = sb.obs_lo;
         1:       w = sb.obs_hi;
         2:       w = sb.clr_lo;
         default: w = sb.clr_hi;
      endcase
      v = roi_scoreboard::field(w, int'($urandom_range(3))) + int'($urandom_range(4)) - 2;
      if ($urandom_range(1) == 1) v = -v;
      return v[15:0];
   endfunction

   function automatic logic [COORD_W-1:0] span_coord();
      int v;
      v = int'($urandom_range(12000)) - 6000;
      return v[15:0];
   endfunction

   function automatic roi_point_type random_point();
      roi_point_type       p;
      logic [COORD_W-1:0]  c[3];
      int unsigned         sel;
      int                  i;
      sel = $urandom_range(99);
      for (i = 0; i < 3; i++) begin
         if (sel < 45) begin
            c[i] = span_coord();
         end else if (sel < 75) begin
            c[i] = ($urandom_range(2) == 0) ? span_coord() : near_bound();
         end else if (sel < 90) begin
            c[i] = 16'($urandom_range(16'hFFFF));
         end else begin
            case ($urandom_range(6))
               0:       c[i] = 16'h8000;
               1:       c[i] = 16'h8001;
               2:       c[i] = 16'hFFFF;
               3:       c[i] = 16'h0000;
               4:       c[i] = 16'h0001;
               5:       c[i] = 16'h7FFE;
               default: c[i] = 16'h7FFF;
            endcase
         end
      end
      p.x      = c[0];
      p.y      = c[1];
      p.z      = c[2];
      p.finite = ($urandom_range(99) < 92);
      p.start  = ($urandom_range(99) < 4);
      return p;
   endfunction

   // offer one point, idling first at the current rate, and note it once accepted
   task automatic send_point(roi_point_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.point_x     <= p.x;
      req_bus.point_y     <= p.y;
      req_bus.point_z     <= p.z;
      req_bus.is_finite   <= p.finite;
      req_bus.cloud_start <= p.start;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(p);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [BOUNDS_W-1:0] v);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= v;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sb.set_register(idx, v);
      @(posedge clock);
   endtask

   task automatic write_gates(logic [BOUNDS_W-1:0] ol, logic [BOUNDS_W-1:0] oh,
                              logic [BOUNDS_W-1:0] cl, logic [BOUNDS_W-1:0] ch,
                              logic [STRIDE_W-1:0] s);
      write_register(REG_OBS_LOWER, ol);
      write_register(REG_OBS_UPPER, oh);
      write_register(REG_CLR_LOWER, cl);
      write_register(REG_CLR_UPPER, ch);
      write_register(REG_CLR_STRIDE, {{(BOUNDS_W-STRIDE_W){1'b0}}, s});
   endtask

   // drop the request, let every gated point come back, then let the pipe settle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // gate settings for one random phase; phases 1 to 3 use the extreme gate settings
   task automatic program_phase(int unsigned ph);
      logic [BOUNDS_W-1:0] ol;
      logic [BOUNDS_W-1:0] oh;
      logic [BOUNDS_W-1:0] cl;
      logic [BOUNDS_W-1:0] ch;
      logic [BOUNDS_W-1:0] tmp;
      logic [STRIDE_W-1:0] s;
      int unsigned         kind;
      kind = (ph < 4) ? ph : $urandom_range(99);
      random_box(ol, oh);
      random_box(cl, ch);
      if (kind == 1 || (kind >= 78 && kind < 84)) begin
         // widest possible gates
         ol = WIDE_LOWER;
         oh = WIDE_UPPER;
         cl = WIDE_LOWER;
         ch = WIDE_UPPER;
      end else if (kind == 2 || (kind >= 84 && kind < 90)) begin
         // all zeros and all ones: the all-ones clearing gate has a negative range maximum and never passes
         ol = '0;
         oh = '0;
         cl = '1;
         ch = '1;
      end else if (kind == 3 || (kind >= 70 && kind < 78)) begin
         ol = {$urandom, $urandom};
         oh = {$urandom, $urandom};
         cl = {$urandom, $urandom};
         ch = {$urandom, $urandom};
      end else if (kind >= 90) begin
         // inverted bounds on one gate
         if ($urandom_range(1) == 1) begin
            tmp = ol;
            ol  = oh;
            oh  = tmp;
         end else begin
            tmp = cl;
            cl  = ch;
            ch  = tmp;
         end
      end
      case (ph)
         0:       s = '0;
         1:       s = '1;
         2:       s = STRIDE_W'(1);
         default: begin
            case ($urandom_range(9))
               0, 1:    s = STRIDE_W'($urandom_range(255));
               2:       s = '0;
               3:       s = '1;
               default: s = STRIDE_W'($urandom_range(1, 8));
            endcase
         end
      endcase
      write_gates(ol, oh, cl, ch, s);
      // writes to the unused indexes must change nothing
      if ($urandom_range(3) == 0)
         write_register(CSR_INDEX_W'($urandom_range(NUM_REGS, (1 << CSR_INDEX_W) - 1)),
                        {$urandom, $urandom});
   endtask

   initial begin : stimulus
      int unsigned ph;
      int unsigned n;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.point_x     <= '0;
      req_bus.point_y     <= '0;
      req_bus.point_z     <= '0;
      req_bus.is_finite   <= 1'b0;
      req_bus.cloud_start <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= '0;
      csr_bus.wdata       <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset gates with the coordinate extremes
      send_point(pt(0, 0, 0, 1'b1, 1'b1));
      send_point(pt(32767, 32767, 32767, 1'b1, 1'b0));
      send_point(pt(-32768, -32768, -32768, 1'b1, 1'b0));
      wait_idle();

      // known gates, stride zero acting as one
      write_gates(pack4(-1000, 0, -500, -5), pack4(1000, 1000, 500, 1200),
                  pack4(0, 0, -1000, 100), pack4(2000, 2000, 1000, 2500), '0);
      send_point(pt(500, -200, 0, 1'b1, 1'b1));
      send_point(pt(1000, 1000, 500, 1'b1, 1'b0));
      send_point(pt(1001, 0, 0, 1'b1, 1'b0));
      // range exactly on the obstacle maximum, then just past it
      send_point(pt(720, -960, 0, 1'b1, 1'b0));
      send_point(pt(720, -961, 0, 1'b1, 1'b0));
      // range exactly on the clearing minimum, then just short of it
      send_point(pt(60, 80, 0, 1'b1, 1'b0));
      send_point(pt(60, 79, 0, 1'b1, 1'b0));
      send_point(pt(0, 0, -501, 1'b1, 1'b0));
      // non-finite point inside both gates
      send_point(pt(500, 0, 0, 1'b0, 1'b0));
      send_point(pt(-1, 0, 0, 1'b1, 1'b0));
      wait_idle();

      // stride lowered in the middle of a cloud
      write_register(REG_CLR_STRIDE, BOUNDS_W'(5));
      send_point(pt(100, 0, 0, 1'b1, 1'b1));
      send_point(pt(200, 0, 0, 1'b1, 1'b0));
      send_point(pt(300, 0, 0, 1'b1, 1'b0));
      wait_idle();
      write_register(REG_CLR_STRIDE, BOUNDS_W'(2));
      send_point(pt(400, 0, 0, 1'b1, 1'b0));
      send_point(pt(500, 0, 0, 1'b1, 1'b0));
      wait_idle();

      // wide gates: saturated abs y and range right at the top
      write_gates(WIDE_LOWER, WIDE_UPPER, WIDE_LOWER, WIDE_UPPER, STRIDE_W'(1));
      send_point(pt(0, -32767, 32767, 1'b1, 1'b1));
      send_point(pt(-32768, -32768, -32768, 1'b1, 1'b0));

      // random phases, each with fresh gate settings
      for (ph = 0; ph < PHASES; ph++) begin
         if (ph == 5) begin
            send_idle_pct = 87;
            recv_idle_pct = 17;
         end else if (ph == 10) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         wait_idle();
         program_phase(ph);
         if (ph == HOLD_PHASE) hold_req = 1'b1;
         for (n = 0; n < PHASE_POINTS; n++) send_point(random_point());
      end
      wait_idle();

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("point_cloud_roi_gate_core verification clean");
      end else begin
         $display("point_cloud_roi_gate_core verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/prg_pkg.sv
sv/prg_if.sv
sv/prg_front.sv
sv/prg_queue.sv
sv/prg_back.sv
sv/point_cloud_roi_gate_core.sv
verif/tb_top.sv
